FILE: src/lam_pkg.sv
// Shared types and constants of the look-at orientation matrix unit.
package lam_pkg;

    // Q1.14 value of 1.0.
    localparam int FX_ONE = 16384;
    localparam int FX_W = 16;
    // Width of an exact difference or a cross product before normalization.
    localparam int WIDE_W = 33;
    // Component magnitudes are brought under 2^30 before squaring.
    localparam int MAG_W = 30;
    localparam int SQ_W = 2 * MAG_W;
    localparam int SUM_W = SQ_W + 2;
    localparam int ISQRT_STEPS = 31;
    localparam int ROOT_W = 31;
    localparam int DEN_W = ROOT_W + 1;
    localparam int DIV_STEPS = 15;
    localparam int REM_W = MAG_W + DIV_STEPS + 2;
    localparam int PROD_W = 2 * FX_W;

    typedef logic [2:0][FX_W-1:0] vec_t;
    typedef logic [2:0][WIDE_W-1:0] wide_vec_t;

    // Side data that rides along with an item through a pipeline section.
    typedef struct packed {
        logic mode;
        vec_t a;
        vec_t b;
    } tag_t;

endpackage

FILE: src/lam_norm.sv
// Pipelined fixed-point vector normalizer: scaling, squares, square root, division.
module lam_norm (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  lam_pkg::wide_vec_t in_vec,
    input  lam_pkg::tag_t      in_tag,
    output logic               out_valid,
    output lam_pkg::vec_t      out_vec,
    output lam_pkg::tag_t      out_tag
);

    typedef struct packed {
        logic [2:0] neg;
        logic [2:0][lam_pkg::MAG_W-1:0] mag;
        lam_pkg::tag_t tag;
    } carry_t;

    // Scaling stage.
    logic   sc_valid_reg;
    carry_t sc_c_reg;
    carry_t sc_c_next;

    always_comb
    begin
        logic [2:0][lam_pkg::WIDE_W-1:0] absv;
        logic [lam_pkg::WIDE_W-1:0] all_bits;
        logic [1:0] sh;
        for (int i = 0; i < 3; i++)
        begin
            sc_c_next.neg[i] = in_vec[i][lam_pkg::WIDE_W-1];
            absv[i] = in_vec[i][lam_pkg::WIDE_W-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
        end
        all_bits = absv[0] | absv[1] | absv[2];
        // The largest magnitude has the highest set bit of the OR of all three.
        if (all_bits[32])
            sh = 2'd3;
        else if (all_bits[31])
            sh = 2'd2;
        else if (all_bits[30])
            sh = 2'd1;
        else
            sh = 2'd0;
        for (int i = 0; i < 3; i++)
            sc_c_next.mag[i] = lam_pkg::MAG_W'(absv[i] >> sh);
        sc_c_next.tag = in_tag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sc_valid_reg <= 1'b0;
        else if (en)
            sc_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sc_c_reg <= sc_c_next;
    end

    // Squares.
    logic   sq_valid_reg;
    carry_t sq_c_reg;
    logic [2:0][lam_pkg::SQ_W-1:0] sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_valid_reg <= 1'b0;
        else if (en)
            sq_valid_reg <= sc_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_c_reg <= sc_c_reg;
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= lam_pkg::SQ_W'(sc_c_reg.mag[i]) * lam_pkg::SQ_W'(sc_c_reg.mag[i]);
        end
    end

    // Sum of squares.
    logic   su_valid_reg;
    carry_t su_c_reg;
    logic [lam_pkg::SUM_W-1:0] su_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            su_valid_reg <= 1'b0;
        else if (en)
            su_valid_reg <= sq_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            su_c_reg <= sq_c_reg;
            su_reg <= lam_pkg::SUM_W'(sq_reg[0]) + lam_pkg::SUM_W'(sq_reg[1])
                    + lam_pkg::SUM_W'(sq_reg[2]);
        end
    end

    // Square root, one result bit per stage.
    logic   rt_valid_reg [lam_pkg::ISQRT_STEPS];
    carry_t rt_c_reg     [lam_pkg::ISQRT_STEPS];
    logic [lam_pkg::SUM_W-1:0] rt_s_reg [lam_pkg::ISQRT_STEPS];
    logic [lam_pkg::SUM_W-1:0] rt_r_reg [lam_pkg::ISQRT_STEPS];

    for (genvar k = 0; k < lam_pkg::ISQRT_STEPS; k++)
    begin : g_root
        localparam logic [lam_pkg::SUM_W-1:0] BIT_VAL =
            lam_pkg::SUM_W'(1) << (2 * (lam_pkg::ISQRT_STEPS - 1 - k));
        logic   v_prev;
        carry_t c_prev;
        logic [lam_pkg::SUM_W-1:0] s_prev, r_prev, s_next, r_next, trial;

        if (k == 0)
        begin : g_first
            assign v_prev = su_valid_reg;
            assign c_prev = su_c_reg;
            assign s_prev = su_reg;
            assign r_prev = '0;
        end
        else
        begin : g_rest
            assign v_prev = rt_valid_reg[k-1];
            assign c_prev = rt_c_reg[k-1];
            assign s_prev = rt_s_reg[k-1];
            assign r_prev = rt_r_reg[k-1];
        end

        always_comb
        begin
            trial = r_prev + BIT_VAL;
            if (s_prev >= trial)
            begin
                s_next = s_prev - trial;
                r_next = (r_prev >> 1) + BIT_VAL;
            end
            else
            begin
                s_next = s_prev;
                r_next = r_prev >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rt_valid_reg[k] <= 1'b0;
            else if (en)
                rt_valid_reg[k] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rt_c_reg[k] <= c_prev;
                rt_s_reg[k] <= s_next;
                rt_r_reg[k] <= r_next;
            end
        end
    end

    // Restoring division, one quotient bit per stage on each of the three lanes.
    logic   dv_valid_reg [lam_pkg::DIV_STEPS];
    carry_t dv_c_reg     [lam_pkg::DIV_STEPS];
    logic   dv_zero_reg  [lam_pkg::DIV_STEPS];
    logic [lam_pkg::DEN_W-1:0] dv_den_reg [lam_pkg::DIV_STEPS];
    logic [2:0][lam_pkg::REM_W-1:0] dv_rem_reg [lam_pkg::DIV_STEPS];
    logic [2:0][lam_pkg::DIV_STEPS-1:0] dv_quo_reg [lam_pkg::DIV_STEPS];

    for (genvar j = 0; j < lam_pkg::DIV_STEPS; j++)
    begin : g_div
        localparam int QB = lam_pkg::DIV_STEPS - 1 - j;
        logic   v_prev;
        carry_t c_prev;
        logic   z_prev;
        logic [lam_pkg::DEN_W-1:0] d_prev;
        logic [2:0][lam_pkg::REM_W-1:0] rem_prev, rem_next;
        logic [2:0][lam_pkg::DIV_STEPS-1:0] q_prev, q_next;
        logic [lam_pkg::REM_W-1:0] dsh;

        if (j == 0)
        begin : g_first
            logic [lam_pkg::ROOT_W-1:0] root;
            assign root = rt_r_reg[lam_pkg::ISQRT_STEPS-1][lam_pkg::ROOT_W-1:0];
            assign v_prev = rt_valid_reg[lam_pkg::ISQRT_STEPS-1];
            assign c_prev = rt_c_reg[lam_pkg::ISQRT_STEPS-1];
            assign z_prev = (root == '0);
            assign d_prev = {root, 1'b0};
            // Numerator 2 * |c| * 16384 + L rounds the quotient half up.
            for (genvar i = 0; i < 3; i++)
            begin : g_lane
                assign rem_prev[i] = (lam_pkg::REM_W'(c_prev.mag[i]) << lam_pkg::DIV_STEPS)
                                   + lam_pkg::REM_W'(root);
            end
            assign q_prev = '0;
        end
        else
        begin : g_rest
            assign v_prev = dv_valid_reg[j-1];
            assign c_prev = dv_c_reg[j-1];
            assign z_prev = dv_zero_reg[j-1];
            assign d_prev = dv_den_reg[j-1];
            assign rem_prev = dv_rem_reg[j-1];
            assign q_prev = dv_quo_reg[j-1];
        end

        always_comb
        begin
            dsh = lam_pkg::REM_W'(d_prev) << QB;
            for (int i = 0; i < 3; i++)
            begin
                q_next[i] = q_prev[i];
                if (rem_prev[i] >= dsh)
                begin
                    rem_next[i] = rem_prev[i] - dsh;
                    q_next[i][QB] = 1'b1;
                end
                else
                begin
                    rem_next[i] = rem_prev[i];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[j] <= 1'b0;
            else if (en)
                dv_valid_reg[j] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_c_reg[j] <= c_prev;
                dv_zero_reg[j] <= z_prev;
                dv_den_reg[j] <= d_prev;
                dv_rem_reg[j] <= rem_next;
                dv_quo_reg[j] <= q_next;
            end
        end
    end

    // Sign stage.
    logic          out_valid_reg;
    lam_pkg::vec_t out_vec_reg;
    lam_pkg::tag_t out_tag_reg;
    lam_pkg::vec_t out_vec_next;

    always_comb
    begin
        logic [lam_pkg::FX_W-1:0] q;
        for (int i = 0; i < 3; i++)
        begin
            // A zero-length vector gives a zero vector.
            q = dv_zero_reg[lam_pkg::DIV_STEPS-1] ? '0
              : lam_pkg::FX_W'(dv_quo_reg[lam_pkg::DIV_STEPS-1][i]);
            out_vec_next[i] = dv_c_reg[lam_pkg::DIV_STEPS-1].neg[i] ? (~q + 1'b1) : q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_valid_reg[lam_pkg::DIV_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_vec_reg <= out_vec_next;
            out_tag_reg <= dv_c_reg[lam_pkg::DIV_STEPS-1].tag;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_vec = out_vec_reg;
    assign out_tag = out_tag_reg;

endmodule

FILE: src/lam_cross.sv
// Two-stage exact cross product of two Q1.14 vectors.
module lam_cross (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  lam_pkg::vec_t      in_a,
    input  lam_pkg::vec_t      in_b,
    input  lam_pkg::tag_t      in_tag,
    output logic               out_valid,
    output lam_pkg::wide_vec_t out_vec,
    output lam_pkg::tag_t      out_tag
);

    logic          pr_valid_reg;
    lam_pkg::tag_t pr_tag_reg;
    logic signed [lam_pkg::PROD_W-1:0] pr_reg [6];

    logic               out_valid_reg;
    lam_pkg::wide_vec_t out_vec_reg;
    lam_pkg::tag_t      out_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pr_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            pr_valid_reg <= in_valid;
            out_valid_reg <= pr_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_tag_reg <= in_tag;
            pr_reg[0] <= $signed(in_a[1]) * $signed(in_b[2]);
            pr_reg[1] <= $signed(in_a[2]) * $signed(in_b[1]);
            pr_reg[2] <= $signed(in_a[2]) * $signed(in_b[0]);
            pr_reg[3] <= $signed(in_a[0]) * $signed(in_b[2]);
            pr_reg[4] <= $signed(in_a[0]) * $signed(in_b[1]);
            pr_reg[5] <= $signed(in_a[1]) * $signed(in_b[0]);
            out_tag_reg <= pr_tag_reg;
            for (int i = 0; i < 3; i++)
                out_vec_reg[i] <= lam_pkg::WIDE_W'(pr_reg[2*i])
                                - lam_pkg::WIDE_W'(pr_reg[2*i+1]);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_vec = out_vec_reg;
    assign out_tag = out_tag_reg;

endmodule

FILE: src/look_at_orientation_matrix_unit.sv
// Top level of the look-at orientation matrix unit.
//
// Input channel: in_valid / in_stall with position, target and up vector in
// signed Q16.16. Output channel: out_valid / out_stall with the rows right,
// upward and forward in signed Q1.14. A beat moves when valid is high and
// stall is low. The configuration channel cfg_valid / cfg_ready writes the
// one-bit mode register; cfg_ready is always high. Mode 0 takes the forward
// axis from the direction, mode 1 keeps the up vector as the Y axis.
//
// Throughput is one item per cycle while the receiver does not stall. An
// accepted input beat passes three normalizers of 50 stages each (a 31-stage
// square root and a 15-stage divider dominate), two 2-stage cross products
// and the output register. The two leading normalizers run side by side.
//
// Reset clears every valid bit and sets mode to 0. While the receiver stalls
// a waiting result, the whole pipeline holds and in_stall is raised; items
// inside are kept in place and nothing is dropped or repeated.
module look_at_orientation_matrix_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    input  logic [31:0] look_x,
    input  logic [31:0] look_y,
    input  logic [31:0] look_z,
    input  logic [31:0] up_x,
    input  logic [31:0] up_y,
    input  logic [31:0] up_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] right_x,
    output logic [15:0] right_y,
    output logic [15:0] right_z,
    output logic [15:0] upward_x,
    output logic [15:0] upward_y,
    output logic [15:0] upward_z,
    output logic [15:0] forward_x,
    output logic [15:0] forward_y,
    output logic [15:0] forward_z
);

    logic mode_reg;
    logic en;
    logic out_valid_reg;
    lam_pkg::vec_t rx_reg, ry_reg, rz_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (cfg_valid)
            mode_reg <= cfg_data;
    end

    assign en = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    lam_pkg::wide_vec_t dir_vec, up_vec;
    lam_pkg::tag_t      in_tag;

    always_comb
    begin
        dir_vec[0] = {look_x[31], look_x} - {pos_x[31], pos_x};
        dir_vec[1] = {look_y[31], look_y} - {pos_y[31], pos_y};
        dir_vec[2] = {look_z[31], look_z} - {pos_z[31], pos_z};
        up_vec[0] = {up_x[31], up_x};
        up_vec[1] = {up_y[31], up_y};
        up_vec[2] = {up_z[31], up_z};
        in_tag.mode = mode_reg;
        in_tag.a = '0;
        in_tag.b = '0;
    end

    logic          nd_valid, nu_valid;
    lam_pkg::vec_t dn_vec, un_vec;
    lam_pkg::tag_t nd_tag, nu_tag;

    lam_norm u_norm_dir (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(in_valid), .in_vec(dir_vec), .in_tag(in_tag),
        .out_valid(nd_valid), .out_vec(dn_vec), .out_tag(nd_tag)
    );

    lam_norm u_norm_up (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(in_valid), .in_vec(up_vec), .in_tag(in_tag),
        .out_valid(nu_valid), .out_vec(un_vec), .out_tag(nu_tag)
    );

    // Both leading normalizers run in lock step; the up lane's copy is unused.
    lam_pkg::tag_t c1_in_tag;

    always_comb
    begin
        c1_in_tag.mode = nd_tag.mode;
        c1_in_tag.a = dn_vec;
        c1_in_tag.b = (nu_valid && nu_tag.mode) ? un_vec : un_vec;
    end

    logic               c1_valid;
    lam_pkg::wide_vec_t c1_vec;
    lam_pkg::tag_t      c1_tag;

    lam_cross u_cross_x (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(nd_valid), .in_a(un_vec), .in_b(dn_vec), .in_tag(c1_in_tag),
        .out_valid(c1_valid), .out_vec(c1_vec), .out_tag(c1_tag)
    );

    logic          nx_valid;
    lam_pkg::vec_t nx_vec;
    lam_pkg::tag_t nx_tag;

    lam_norm u_norm_x (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(c1_valid), .in_vec(c1_vec), .in_tag(c1_tag),
        .out_valid(nx_valid), .out_vec(nx_vec), .out_tag(nx_tag)
    );

    // Mode 0 forms forward x right; mode 1 forms right x up.
    lam_pkg::vec_t c2_a, c2_b;
    lam_pkg::tag_t c2_in_tag;

    always_comb
    begin
        c2_in_tag.mode = nx_tag.mode;
        c2_in_tag.a = nx_vec;
        if (nx_tag.mode)
        begin
            c2_a = nx_vec;
            c2_b = nx_tag.b;
            c2_in_tag.b = nx_tag.b;
        end
        else
        begin
            c2_a = nx_tag.a;
            c2_b = nx_vec;
            c2_in_tag.b = nx_tag.a;
        end
    end

    logic               c2_valid;
    lam_pkg::wide_vec_t c2_vec;
    lam_pkg::tag_t      c2_tag;

    lam_cross u_cross_last (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(nx_valid), .in_a(c2_a), .in_b(c2_b), .in_tag(c2_in_tag),
        .out_valid(c2_valid), .out_vec(c2_vec), .out_tag(c2_tag)
    );

    logic          nl_valid;
    lam_pkg::vec_t nl_vec;
    lam_pkg::tag_t nl_tag;

    lam_norm u_norm_last (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(c2_valid), .in_vec(c2_vec), .in_tag(c2_tag),
        .out_valid(nl_valid), .out_vec(nl_vec), .out_tag(nl_tag)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= nl_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg <= nl_tag.a;
            if (nl_tag.mode)
            begin
                ry_reg <= nl_tag.b;
                rz_reg <= nl_vec;
            end
            else
            begin
                ry_reg <= nl_vec;
                rz_reg <= nl_tag.b;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign right_x = rx_reg[0];
    assign right_y = rx_reg[1];
    assign right_z = rx_reg[2];
    assign upward_x = ry_reg[0];
    assign upward_y = ry_reg[1];
    assign upward_z = ry_reg[2];
    assign forward_x = rz_reg[0];
    assign forward_y = rz_reg[1];
    assign forward_z = rz_reg[2];

    // Normalized components never exceed one in magnitude.
    a_right_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(right_x) <= 16'sd16384 && $signed(right_x) >= -16'sd16384))
        else $error("right_x out of range");

    a_forward_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(forward_z) <= 16'sd16384 && $signed(forward_z) >= -16'sd16384))
        else $error("forward_z out of range");

    // The leading normalizers must stay in lock step.
    a_lock_step: assert property (@(posedge clk) disable iff (!rst_n)
        nd_valid == nu_valid)
        else $error("direction and up normalizers out of step");

endmodule

FILE: tb/look_at_orientation_checker.sv
// Checker that predicts and compares the rows of the look-at orientation matrix unit.
`timescale 1ns / 1ps

module look_at_orientation_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    input  logic [31:0] look_x,
    input  logic [31:0] look_y,
    input  logic [31:0] look_z,
    input  logic [31:0] up_x,
    input  logic [31:0] up_y,
    input  logic [31:0] up_z,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [15:0] right_x,
    input  logic [15:0] right_y,
    input  logic [15:0] right_z,
    input  logic [15:0] upward_x,
    input  logic [15:0] upward_y,
    input  logic [15:0] upward_z,
    input  logic [15:0] forward_x,
    input  logic [15:0] forward_y,
    input  logic [15:0] forward_z,
    output int          error_count,
    output int          pending_rows,
    output int          rows_checked
);
    typedef longint signed axis_t [3];

    typedef struct {
        logic [15:0] comp [9];
    } frame_t;

    logic  mode_q;
    frame_t frame_q [$];

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned r;
        longint unsigned bit_v;
        r = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > s)
            bit_v = bit_v >> 2;
        while (bit_v != 0)
        begin
            if (s >= r + bit_v)
            begin
                s = s - (r + bit_v);
                r = (r >> 1) + bit_v;
            end
            else
                r = r >> 1;
            bit_v = bit_v >> 2;
        end
        return r;
    endfunction

    function automatic axis_t unit_axis(axis_t v);
        longint unsigned mag [3];
        bit neg [3];
        longint unsigned m;
        longint unsigned s;
        longint unsigned len;
        longint unsigned q;
        axis_t o;
        m = 0;
        s = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? longint'(-v[i]) : longint'(v[i]);
            if (mag[i] > m)
                m = mag[i];
        end
        while (m >= (64'd1 << 30))
        begin
            m = m >> 1;
            for (int i = 0; i < 3; i++)
                mag[i] = mag[i] >> 1;
        end
        for (int i = 0; i < 3; i++)
            s = s + mag[i] * mag[i];
        len = int_sqrt(s);
        for (int i = 0; i < 3; i++)
        begin
            q = 0;
            if (len != 0)
                q = (2 * mag[i] * lam_pkg::FX_ONE + len) / (2 * len);
            o[i] = neg[i] ? -longint'(q) : longint'(q);
        end
        return o;
    endfunction

    function automatic axis_t cross_of(axis_t a, axis_t b);
        axis_t o;
        o[0] = a[1] * b[2] - a[2] * b[1];
        o[1] = a[2] * b[0] - a[0] * b[2];
        o[2] = a[0] * b[1] - a[1] * b[0];
        return o;
    endfunction

    function automatic frame_t orientation_rows(logic md, logic [31:0] p [3],
                                                logic [31:0] l [3], logic [31:0] u [3]);
        axis_t dir;
        axis_t upv;
        axis_t dn;
        axis_t un;
        axis_t rx;
        axis_t ry;
        axis_t rz;
        frame_t f;
        for (int i = 0; i < 3; i++)
        begin
            dir[i] = longint'($signed(l[i])) - longint'($signed(p[i]));
            upv[i] = longint'($signed(u[i]));
        end
        dn = unit_axis(dir);
        un = unit_axis(upv);
        rx = unit_axis(cross_of(un, dn));
        if (md == 1'b0)
        begin
            rz = dn;
            ry = unit_axis(cross_of(rz, rx));
        end
        else
        begin
            ry = un;
            rz = unit_axis(cross_of(rx, ry));
        end
        for (int i = 0; i < 3; i++)
        begin
            f.comp[i] = rx[i][15:0];
            f.comp[3 + i] = ry[i][15:0];
            f.comp[6 + i] = rz[i][15:0];
        end
        return f;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [31:0] p [3];
        logic [31:0] l [3];
        logic [31:0] u [3];
        logic [15:0] got [9];
        frame_t want;
        if (!rst_n)
        begin
            mode_q <= 1'b0;
            error_count <= 0;
            rows_checked <= 0;
            pending_rows <= 0;
            frame_q.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                p = '{pos_x, pos_y, pos_z};
                l = '{look_x, look_y, look_z};
                u = '{up_x, up_y, up_z};
                frame_q.push_back(orientation_rows(mode_q, p, l, u));
            end
            if (cfg_valid && cfg_ready)
                mode_q <= cfg_data;
            if (out_valid && !out_stall)
            begin
                got = '{right_x, right_y, right_z, upward_x, upward_y, upward_z,
                        forward_x, forward_y, forward_z};
                rows_checked <= rows_checked + 1;
                if (frame_q.size() == 0)
                begin
                    if (error_count < 10)
                        $display("ERROR: result beat with no expectation waiting");
                    error_count <= error_count + 1;
                end
                else
                begin
                    want = frame_q.pop_front();
                    if (want.comp != got)
                    begin
                        if (error_count < 10)
                            for (int i = 0; i < 9; i++)
                                if (want.comp[i] != got[i])
                                    $display("ERROR: beat %0d component %0d expected %0d got %0d",
                                             rows_checked, i, $signed(want.comp[i]),
                                             $signed(got[i]));
                        error_count <= error_count + 1;
                    end
                end
            end
            pending_rows <= frame_q.size();
        end
    end
endmodule

FILE: tb/tb_look_at_orientation_matrix_unit.sv
// Testbench top of the look-at orientation matrix unit: stimulus and verdict.
`timescale 1ns / 1ps

module tb_look_at_orientation_matrix_unit;
    localparam int LATENCY = 155;
    localparam int RANDOM_ITEMS = 700;
    localparam longint CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] look_x;
    logic [31:0] look_y;
    logic [31:0] look_z;
    logic [31:0] up_x;
    logic [31:0] up_y;
    logic [31:0] up_z;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] right_x;
    logic [15:0] right_y;
    logic [15:0] right_z;
    logic [15:0] upward_x;
    logic [15:0] upward_y;
    logic [15:0] upward_z;
    logic [15:0] forward_x;
    logic [15:0] forward_y;
    logic [15:0] forward_z;
    int          error_count;
    int          pending_rows;
    int          rows_checked;
    longint      cycle_count;
    bit          idle_off;
    int          items_sent;

    look_at_orientation_matrix_unit i_dut (.*);

    look_at_orientation_checker i_checker (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver stalls in random bursts until the quiet tail of the run.
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!idle_off && $urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, 10);
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            3: return $urandom_range(0, 16) << 16;
            4: return 32'(-int'($urandom_range(0, 65536 * 8)));
            default: return 32'(int'($urandom_range(0, 200000)) - 100000);
        endcase
    endfunction

    task automatic send_item(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
                             logic [31:0] ux, logic [31:0] uy, logic [31:0] uz);
        int gap;
        if (!idle_off && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        {pos_x, pos_y, pos_z} <= {px, py, pz};
        {look_x, look_y, look_z} <= {lx, ly, lz};
        {up_x, up_y, up_z} <= {ux, uy, uz};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_rows != 0)
            @(negedge clk);
    endtask

    task automatic write_mode(logic value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_item();
        logic [31:0] p [3];
        logic [31:0] u [3];
        logic [31:0] l [3];
        for (int i = 0; i < 3; i++)
        begin
            p[i] = rand_coord();
            l[i] = rand_coord();
            u[i] = rand_coord();
        end
        // Now and then the target meets the position, the up vector is zero or it is parallel.
        case ($urandom_range(0, 15))
            0: l = p;
            1: u = '{32'd0, 32'd0, 32'd0};
            2:
            begin
                l = '{p[0] + 32'h10000, p[1], p[2]};
                u = '{32'h20000, 32'd0, 32'd0};
            end
            default: ;
        endcase
        send_item(p[0], p[1], p[2], l[0], l[1], l[2], u[0], u[1], u[2]);
    endtask

    initial
    begin
        logic [31:0] mx;
        logic [31:0] mn;
        cycle_count = 0;
        idle_off = 1'b0;
        items_sent = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        in_valid = 1'b0;
        {pos_x, pos_y, pos_z, look_x, look_y, look_z, up_x, up_y, up_z} = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        for (int m = 0; m < 2; m++)
        begin
            write_mode(m[0]);
            send_item(0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0);
            send_item(0, 0, 0, 0, 0, 32'h10000, 0, 32'h10000, 0);
            // Target equal to position.
            send_item(5, 6, 7, 5, 6, 7, 0, 32'h10000, 0);
            // Zero up vector.
            send_item(0, 0, 0, 1, 2, 3, 0, 0, 0);
            // Up parallel to the direction.
            send_item(0, 0, 0, 0, 32'h30000, 0, 0, 32'h10000, 0);
            send_item(mn, mn, mn, mx, mx, mx, mx, mn, mx);
            send_item(mx, mx, mx, mn, mn, mn, mn, mx, mn);
            send_item(mn, mx, 0, mx, mn, 0, mx, mx, mx);
            send_item(0, 0, 0, 1, 0, 0, 0, 0, 1);
            send_item(32'hFFFF_FFFF, 0, 0, 0, 32'hFFFF_FFFF, 1, mn, 1, mx);
            drain();
        end
        for (int phase = 0; phase < 4; phase++)
        begin
            write_mode(phase[0] ^ 1'b1);
            if (phase == 3)
                idle_off = 1'b1;
            for (int k = 0; k < RANDOM_ITEMS / 4; k++)
            begin
                random_item();
                // A pause in the middle lets the pipeline empty completely.
                if (phase == 1 && k == 60)
                    drain();
            end
            drain();
        end
        repeat (LATENCY + 10) @(negedge clk);
        $display("Sent %0d items over both modes and checked %0d result beats.",
                 items_sent, rows_checked);
        if (error_count == 0 && pending_rows == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
